FILE: sv/rational_arithmetic_reduce_defines.svh
// Assertion macros shared by the checker of the rational reduction block.
// No dependencies.
`ifndef RATIONAL_ARITHMETIC_REDUCE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_REDUCE_DEFINES_SVH
`define RAR_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAR_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: sv/rar_pkg.sv
// Package of the rational reduction block: widths, operation codes, stage types.
// No dependencies.
package rar_pkg;
  localparam int unsigned OperandWidth = 16;
  localparam int unsigned ProdWidth = 2 * OperandWidth;
  localparam int unsigned NumWidth = ProdWidth + 1;
  localparam int unsigned DenWidth = ProdWidth;
  localparam int unsigned MagWidth = NumWidth;
  localparam int unsigned ShiftWidth = $clog2(MagWidth + 1);

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic signed [15:0] first_numerator;
    logic signed [15:0] first_denominator;
    logic signed [15:0] second_numerator;
    logic signed [15:0] second_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [32:0] result_numerator;
    logic signed [31:0] result_denominator;
    logic zero_denominator;
  } out_item_t;

  // Raw fraction after cross multiplication, carried as sign and magnitude.
  typedef struct packed {
    logic n_neg;
    logic d_neg;
    logic [MagWidth-1:0] n_mag;
    logic [MagWidth-1:0] d_mag;
  } raw_t;
endpackage

FILE: sv/rar_stream_if.sv
// Valid/ready channel interface carrying one payload item.
// No dependencies; the payload type is a parameter.
interface rar_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/rar_mult.sv
// Cross multiplication in three stages: products, sum, magnitude.
// Depends on rar_pkg.
module rar_mult (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  rar_pkg::in_item_t in_data_i,
  input  logic             advance_i,
  output logic             out_valid_o,
  output rar_pkg::raw_t    out_data_o
);
  localparam int unsigned W = rar_pkg::OperandWidth;
  localparam int unsigned P = rar_pkg::ProdWidth;
  localparam int unsigned M = rar_pkg::MagWidth;

  logic signed [W-1:0] p1, q1, p2, q2;
  logic signed [W-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
  logic signed [P-1:0] pa_d, pb_d, pd_d;
  logic signed [P-1:0] pa_q, pb_q, pd_q;
  logic [1:0] cmd_q;
  logic v1_q, v2_q, v3_q;
  logic signed [M-1:0] n_d, n_q;
  logic signed [P-1:0] d_q;
  rar_pkg::raw_t raw_d, raw_q;

  assign p1 = in_data_i.first_numerator[W-1:0];
  assign q1 = in_data_i.first_denominator[W-1:0];
  assign p2 = in_data_i.second_numerator[W-1:0];
  assign q2 = in_data_i.second_denominator[W-1:0];

  always_comb begin
    a_x = p1; a_y = q2; b_x = p2; b_y = q1; c_x = q1; c_y = q2;
    case (rar_pkg::cmd_e'(in_data_i.command))
      rar_pkg::CmdMul: begin a_y = p2; end
      rar_pkg::CmdDiv: begin c_y = p2; end
      default: begin end
    endcase
    pa_d = a_x * a_y;
    pb_d = b_x * b_y;
    pd_d = c_x * c_y;
  end

  always_comb begin
    case (rar_pkg::cmd_e'(cmd_q))
      rar_pkg::CmdAdd: n_d = M'(pa_q) + M'(pb_q);
      rar_pkg::CmdSub: n_d = M'(pa_q) - M'(pb_q);
      default: n_d = M'(pa_q);
    endcase
  end

  always_comb begin
    raw_d.n_neg = n_q[M-1];
    raw_d.d_neg = d_q[P-1];
    raw_d.n_mag = n_q[M-1] ? M'(-n_q) : M'(n_q);
    raw_d.d_mag = d_q[P-1] ? M'(-{d_q[P-1], d_q}) : M'({1'b0, d_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else if (advance_i) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      pa_q <= pa_d; pb_q <= pb_d; pd_q <= pd_d;
      cmd_q <= in_data_i.command;
      n_q <= n_d; d_q <= pd_q;
      raw_q <= raw_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o = raw_q;
endmodule

FILE: sv/rar_gcd_stage.sv
// One pipeline stage of a binary GCD that counts common factors of two (one step per stage).
// Depends on rar_pkg.
module rar_gcd_stage (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  input  logic in_valid_i,
  input  logic [rar_pkg::MagWidth-1:0] a_i,
  input  logic [rar_pkg::MagWidth-1:0] b_i,
  input  logic [rar_pkg::ShiftWidth-1:0] k_i,
  output logic out_valid_o,
  output logic [rar_pkg::MagWidth-1:0] a_o,
  output logic [rar_pkg::MagWidth-1:0] b_o,
  output logic [rar_pkg::ShiftWidth-1:0] k_o
);
  localparam int unsigned M = rar_pkg::MagWidth;
  logic [M-1:0] a_d, b_d, dif;
  logic [rar_pkg::ShiftWidth-1:0] k_d;
  logic valid_q;
  logic [M-1:0] a_q, b_q;
  logic [rar_pkg::ShiftWidth-1:0] k_q;

  // Step on (a, b): pass a zero through, strip common twos, halve an even one, else halve the difference.
  always_comb begin
    a_d = a_i; b_d = b_i; k_d = k_i;
    dif = (a_i > b_i) ? a_i - b_i : b_i - a_i;
    if (a_i == '0 || b_i == '0) begin
      a_d = a_i | b_i; b_d = '0;
    end else if (!a_i[0] && !b_i[0]) begin
      a_d = a_i >> 1; b_d = b_i >> 1; k_d = k_i + 1'b1;
    end else if (!a_i[0]) begin
      a_d = a_i >> 1;
    end else if (!b_i[0]) begin
      b_d = b_i >> 1;
    end else if (a_i > b_i) begin
      a_d = dif >> 1;
    end else begin
      b_d = dif >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (advance_i) valid_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      a_q <= a_d; b_q <= b_d; k_q <= k_d;
    end
  end
  assign out_valid_o = valid_q;
  assign a_o = a_q;
  assign b_o = b_q;
  assign k_o = k_q;
endmodule

FILE: sv/rar_div_stage.sv
// One restoring-division step on numerator and denominator quotients at once.
// Depends on rar_pkg.
module rar_div_stage (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  input  logic in_valid_i,
  input  logic [rar_pkg::MagWidth-1:0] g_i,
  input  logic [rar_pkg::MagWidth-1:0] nr_i,
  input  logic [rar_pkg::MagWidth-1:0] nq_i,
  input  logic [rar_pkg::MagWidth-1:0] dr_i,
  input  logic [rar_pkg::MagWidth-1:0] dq_i,
  output logic out_valid_o,
  output logic [rar_pkg::MagWidth-1:0] nr_o,
  output logic [rar_pkg::MagWidth-1:0] nq_o,
  output logic [rar_pkg::MagWidth-1:0] dr_o,
  output logic [rar_pkg::MagWidth-1:0] dq_o
);
  localparam int unsigned M = rar_pkg::MagWidth;
  logic [M:0] nt, dt;
  logic [M-1:0] nr_d, nq_d, dr_d, dq_d;
  logic valid_q;
  logic [M-1:0] nr_q, nq_q, dr_q, dq_q;

  always_comb begin
    nt = {nr_i, nq_i[M-1]};
    dt = {dr_i, dq_i[M-1]};
    nq_d = {nq_i[M-2:0], 1'b0};
    dq_d = {dq_i[M-2:0], 1'b0};
    nr_d = nt[M-1:0];
    dr_d = dt[M-1:0];
    if (nt >= {1'b0, g_i}) begin
      nr_d = M'(nt - {1'b0, g_i}); nq_d[0] = 1'b1;
    end
    if (dt >= {1'b0, g_i}) begin
      dr_d = M'(dt - {1'b0, g_i}); dq_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (advance_i) valid_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      nr_q <= nr_d; nq_q <= nq_d; dr_q <= dr_d; dq_q <= dq_d;
    end
  end
  assign out_valid_o = valid_q;
  assign nr_o = nr_q;
  assign nq_o = nq_q;
  assign dr_o = dr_q;
  assign dq_o = dq_q;
endmodule

FILE: sv/rational_arithmetic_reduce.sv
// Rational fraction arithmetic with GCD reduction, fully pipelined.
// Stages: 3 multiply, 2*33 GCD, 1 shift, 33 divide and 1 output.
// Throughput: one item per cycle when unstalled.
// The whole pipe stalls as one when the output register is full and not taken.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload is not reset.
// Depends on rar_pkg, rar_stream_if, rar_mult, rar_gcd_stage and rar_div_stage.
module rational_arithmetic_reduce (
  input  logic clk_i,
  input  logic rst_ni,
  rar_stream_if.sink   in_if,
  rar_stream_if.source out_if
);
  localparam int unsigned M = rar_pkg::MagWidth;
  localparam int unsigned GcdSteps = 2 * M;
  localparam int unsigned SW = rar_pkg::ShiftWidth;

  // The pipe moves when the output register is empty or being emptied.
  logic advance;
  logic out_valid_q;
  rar_pkg::out_item_t out_q;
  assign advance = !out_valid_q || out_if.ready;
  assign in_if.ready = advance;

  logic mult_valid;
  rar_pkg::raw_t raw;
  rar_mult u_mult (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid && advance), .in_data_i(in_if.data),
    .advance_i(advance), .out_valid_o(mult_valid), .out_data_o(raw)
  );

  // Side-band: signs travel beside the GCD and divide chains, both magnitudes beside the GCD chain.
  localparam int unsigned Tail = GcdSteps + 1 + M;
  logic [Tail:0] sb_n_neg, sb_d_neg;
  logic [M-1:0] sb_nm [0:GcdSteps];
  logic [M-1:0] sb_dm [0:GcdSteps];
  logic dzero_q;
  assign sb_n_neg[0] = raw.n_neg;
  assign sb_d_neg[0] = raw.d_neg;
  assign sb_nm[0] = raw.n_mag;
  assign sb_dm[0] = raw.d_mag;

  logic [GcdSteps:0] gv;
  logic [M-1:0] ga [0:GcdSteps];
  logic [M-1:0] gb [0:GcdSteps];
  logic [SW-1:0] gk [0:GcdSteps];
  assign gv[0] = mult_valid;
  assign ga[0] = raw.n_mag;
  assign gb[0] = raw.d_mag;
  assign gk[0] = '0;

  // Binary GCD: each stage either halves or subtracts, so 2*M steps suffice.
  for (genvar i = 0; i < GcdSteps; i++) begin : g_gcd
    rar_gcd_stage u_stage (
      .clk_i, .rst_ni, .advance_i(advance), .in_valid_i(gv[i]),
      .a_i(ga[i]), .b_i(gb[i]), .k_i(gk[i]),
      .out_valid_o(gv[i+1]), .a_o(ga[i+1]), .b_o(gb[i+1]), .k_o(gk[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (advance) begin
        sb_n_neg[i+1] <= sb_n_neg[i];
        sb_d_neg[i+1] <= sb_d_neg[i];
        sb_nm[i+1] <= sb_nm[i];
        sb_dm[i+1] <= sb_dm[i];
      end
    end
  end

  // Restore the common power of two; a zero numerator divides by one.
  logic g_v_q;
  logic [M-1:0] g_q, nm_q, dm_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_v_q <= 1'b0;
    else if (advance) g_v_q <= gv[GcdSteps];
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      g_q <= (sb_nm[GcdSteps] == '0) ? M'(1) : (ga[GcdSteps] << gk[GcdSteps]);
      nm_q <= sb_nm[GcdSteps];
      dm_q <= sb_dm[GcdSteps];
      sb_n_neg[GcdSteps+1] <= sb_n_neg[GcdSteps];
      sb_d_neg[GcdSteps+1] <= sb_d_neg[GcdSteps];
      dzero_q <= (sb_dm[GcdSteps] == '0);
    end
  end

  // Divide both magnitudes by g, one quotient bit per stage.
  logic [M:0] dv;
  logic [M-1:0] dg [0:M];
  logic [M-1:0] dnr [0:M];
  logic [M-1:0] dnq [0:M];
  logic [M-1:0] ddr [0:M];
  logic [M-1:0] ddq [0:M];
  logic [M:0] dz;
  assign dv[0] = g_v_q;
  assign dg[0] = g_q;
  assign dnr[0] = '0;
  assign dnq[0] = nm_q;
  assign ddr[0] = '0;
  assign ddq[0] = dm_q;
  assign dz[0] = dzero_q;
  for (genvar j = 0; j < M; j++) begin : g_div
    rar_div_stage u_stage (
      .clk_i, .rst_ni, .advance_i(advance), .in_valid_i(dv[j]), .g_i(dg[j]),
      .nr_i(dnr[j]), .nq_i(dnq[j]), .dr_i(ddr[j]), .dq_i(ddq[j]),
      .out_valid_o(dv[j+1]), .nr_o(dnr[j+1]), .nq_o(dnq[j+1]),
      .dr_o(ddr[j+1]), .dq_o(ddq[j+1])
    );
    always_ff @(posedge clk_i) begin
      if (advance) begin
        dg[j+1] <= dg[j];
        dz[j+1] <= dz[j];
        sb_n_neg[GcdSteps+2+j] <= sb_n_neg[GcdSteps+1+j];
        sb_d_neg[GcdSteps+2+j] <= sb_d_neg[GcdSteps+1+j];
      end
    end
  end

  // Output register: apply signs and hold the item until it is taken.
  rar_pkg::out_item_t out_d;
  always_comb begin
    out_d.result_numerator = sb_n_neg[Tail] ? 33'(-dnq[M]) : 33'(dnq[M]);
    out_d.result_denominator = sb_d_neg[Tail] ? 32'(-ddq[M]) : 32'(ddq[M]);
    out_d.zero_denominator = dz[M];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (advance) out_valid_q <= dv[M];
  end
  always_ff @(posedge clk_i) begin
    if (advance) out_q <= out_d;
  end
  assign out_if.valid = out_valid_q;
  assign out_if.data = out_q;
endmodule

FILE: sv/rar_checker.sv
// Port-level checker for rational_arithmetic_reduce, bound to the top level.
// Depends on rar_pkg and rational_arithmetic_reduce_defines.svh.
`include "rational_arithmetic_reduce_defines.svh"
module rar_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input rar_pkg::out_item_t out_data_i
);
  `RAR_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "output item changed while stalled")
  `RAR_ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !out_valid_i |-> in_ready_i, "input stalled with empty output")
  `RAR_ASSERT_IMPL(a_zero_num, clk_i, rst_ni, out_valid_i && out_data_i.zero_denominator |-> out_data_i.result_denominator == '0, "zero flag with nonzero denominator")
  `RAR_ASSERT_NORST(a_reset_empty, clk_i, !rst_ni |=> !out_valid_i, "output valid during reset")
endmodule

bind rational_arithmetic_reduce rar_checker u_rar_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);

FILE: tb/rational_arithmetic_reduce_tb.sv
// Testbench of the rational fraction reduction block: directed and random fractions,
// checked against a behavioral GCD predictor with random stalls on both channels.
// Depends on rar_pkg, rar_stream_if and rational_arithmetic_reduce.
`timescale 1ns / 1ps
module rational_arithmetic_reduce_tb;
  import rar_pkg::*;

  logic clk_i;
  logic rst_ni;

  rar_stream_if #(.payload_t(in_item_t))  in_if ();
  rar_stream_if #(.payload_t(out_item_t)) out_if ();

  rational_arithmetic_reduce i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // Fractions waiting to be offered, and reduced results waiting to be seen.
  in_item_t  fraction_q[$];
  out_item_t reduced_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned result_count;
  int unsigned zero_den_count;
  bit          stim_done;

  // Binary-free Euclid on 64-bit magnitudes.
  function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Computes the reduced fraction for one item, all sums in 64-bit signed arithmetic.
  function automatic out_item_t reduce_fraction(input in_item_t it);
    out_item_t  r;
    logic signed [63:0] p1, q1, p2, q2, n, d;
    logic [63:0] nm, dm, g;
    p1 = it.first_numerator;
    q1 = it.first_denominator;
    p2 = it.second_numerator;
    q2 = it.second_denominator;
    case (cmd_e'(it.command))
      CmdAdd: begin
        n = p1 * q2 + p2 * q1;
        d = q1 * q2;
      end
      CmdSub: begin
        n = p1 * q2 - p2 * q1;
        d = q1 * q2;
      end
      CmdMul: begin
        n = p1 * p2;
        d = q1 * q2;
      end
      default: begin
        n = p1 * q2;
        d = q1 * p2;
      end
    endcase
    nm = n[63] ? -n : n;
    dm = d[63] ? -d : d;
    if (nm != 0) begin
      g = gcd64(nm, dm);
      nm = nm / g;
      dm = dm / g;
    end
    r.result_numerator   = n[63] ? -nm : nm;
    r.result_denominator = d[63] ? -dm : dm;
    r.zero_denominator   = (d == 0);
    return r;
  endfunction

  function automatic in_item_t make_fraction(input cmd_e c, input int p1, input int q1,
                                             input int p2, input int q2);
    in_item_t it;
    it.command            = c;
    it.first_numerator    = p1[15:0];
    it.first_denominator  = q1[15:0];
    it.second_numerator   = p2[15:0];
    it.second_denominator = q2[15:0];
    return it;
  endfunction

  // Random operand: small values so reductions are common, values with factors of two,
  // full range and extremes.
  function automatic logic [15:0] rand_operand();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3, 4, 5: return 16'($signed($urandom_range(40)) - 20);
      6:       return 16'(($urandom_range(30) + 1) * (1 << $urandom_range(8)));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: offers the head of the queue and pops it when it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        reduced_q.push_back(reduce_fraction(in_if.data));
        void'(fraction_q.pop_front());
      end
      // Decide the next offer from what remains after this handshake.
      if (in_if.valid && !in_if.ready) begin
        // Hold the current item stable until it is taken.
      end else if (fraction_q.size() > (in_if.valid && in_if.ready ? 0 : 0) &&
                   ($urandom_range(99) >= send_idle_pct)) begin
        in_if.valid <= 1'b1;
        in_if.data  <= fraction_q[0];
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random ready, or a long hold-off when one is requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: each result taken is compared with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (reduced_q.size() == 0) begin
        $error("result with no fraction pending");
        error_count++;
      end else begin
        exp_r = reduced_q.pop_front();
        result_count++;
        if (exp_r.zero_denominator) zero_den_count++;
        if (out_if.data.result_numerator !== exp_r.result_numerator) begin
          $error("result_numerator: expected %0d, got %0d",
                 exp_r.result_numerator, out_if.data.result_numerator);
          error_count++;
        end
        if (out_if.data.result_denominator !== exp_r.result_denominator) begin
          $error("result_denominator: expected %0d, got %0d",
                 exp_r.result_denominator, out_if.data.result_denominator);
          error_count++;
        end
        if (out_if.data.zero_denominator !== exp_r.zero_denominator) begin
          $error("zero_denominator: expected %0b, got %0b",
                 exp_r.zero_denominator, out_if.data.zero_denominator);
          error_count++;
        end
      end
    end
  end

  // Watchdog: stops the simulation and reports a failure on timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_drained();
    while (fraction_q.size() != 0 || in_if.valid) @(posedge clk_i);
  endtask

  initial begin
    cycle_count    = 0;
    error_count    = 0;
    result_count   = 0;
    zero_den_count = 0;
    hold_cycles    = 0;
    stim_done      = 1'b0;
    send_idle_pct  = 24;
    recv_idle_pct  = 79;
    @(posedge rst_ni);

    // Directed part: every operation, extremes, zero numerator, zero denominator
    // and both zero, negative denominators.
    fraction_q.push_back(make_fraction(CmdAdd, 1, 2, 1, 3));
    fraction_q.push_back(make_fraction(CmdSub, 1, 2, 1, 2));
    fraction_q.push_back(make_fraction(CmdMul, 6, 4, 2, 9));
    fraction_q.push_back(make_fraction(CmdDiv, 3, 5, 9, 10));
    fraction_q.push_back(make_fraction(CmdAdd, 5, 0, 3, 7));
    fraction_q.push_back(make_fraction(CmdMul, 0, 0, 4, 5));
    fraction_q.push_back(make_fraction(CmdDiv, 7, 3, 0, 5));
    fraction_q.push_back(make_fraction(CmdMul, 0, 7, 5, 3));
    fraction_q.push_back(make_fraction(CmdAdd, 1, -4, 1, 6));
    fraction_q.push_back(make_fraction(CmdSub, -32768, -32768, 32767, -32768));
    fraction_q.push_back(make_fraction(CmdAdd, -32768, 32767, -32768, 32767));
    fraction_q.push_back(make_fraction(CmdAdd, 32767, -32768, 32767, -32768));
    fraction_q.push_back(make_fraction(CmdMul, -32768, 1, -32768, 1));
    fraction_q.push_back(make_fraction(CmdMul, -32768, -32768, -32768, -32768));
    fraction_q.push_back(make_fraction(CmdDiv, -32768, -1, -1, -32768));
    fraction_q.push_back(make_fraction(CmdSub, 32767, 1, -32768, 1));
    fraction_q.push_back(make_fraction(CmdDiv, 32767, 32767, 32767, 32767));
    fraction_q.push_back(make_fraction(CmdSub, -1, -1, -1, -1));
    fraction_q.push_back(make_fraction(CmdAdd, 0, 0, 0, 0));
    fraction_q.push_back(make_fraction(CmdDiv, -12, 0, -8, 0));

    // Long hold-off on the receiver while the sender keeps offering items.
    for (int i = 0; i < 150; i++) begin
      fraction_q.push_back(make_fraction(cmd_e'($urandom_range(3)), $signed(rand_operand()),
                                         $signed(rand_operand()), $signed(rand_operand()),
                                         $signed(rand_operand())));
    end
    hold_cycles = 300;
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 24;
    for (int i = 0; i < 150; i++) begin
      fraction_q.push_back(make_fraction(cmd_e'($urandom_range(3)), $signed(rand_operand()),
                                         $signed(rand_operand()), $signed(rand_operand()),
                                         $signed(rand_operand())));
    end
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 150; i++) begin
      fraction_q.push_back(make_fraction(cmd_e'($urandom_range(3)), $signed(rand_operand()),
                                         $signed(rand_operand()), $signed(rand_operand()),
                                         $signed(rand_operand())));
    end
    wait_drained();

    // Let the pipeline empty, then give it the latency once more.
    while (reduced_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    $display("Checked %0d reduced fractions, %0d of them with a zero denominator,",
             result_count, zero_den_count);
    $display("across all four operations under sender and receiver stalls.");
    if (error_count == 0 && reduced_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
